/* design/assert_macros.svh */
// Assertion macros shared by the RTL of the TGA stream decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

/* design/tga_pkg.sv */
// Shared types, constants and helpers for the TGA true-colour stream decoder.
package tga_pkg;

  localparam int MAX_DIM_BITS = 15;
  localparam int DIM_W        = 16;
  localparam int COORD_W      = 15;

  typedef enum logic [1:0] {
    KIND_PIXEL    = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_BAD_TYPE = 2'd2,
    KIND_BAD_DEPTH = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          red;
    logic [7:0]          green;
    logic [7:0]          blue;
    logic [7:0]          alpha;
    logic [COORD_W-1:0]  column;
    logic [COORD_W-1:0]  row;
    logic                last;
  } res_t;

  function automatic logic [DIM_W-1:0] limit_dim(input logic [DIM_W-1:0] raw);
    logic [DIM_W-1:0] res;
    res = ((raw >> MAX_DIM_BITS) != '0) ? '0 : raw;
    return res;
  endfunction

endpackage

/* design/tga_truecolor_to_rgba_stream_core.sv */
// Top level of the TGA true-colour to RGBA stream decoder.
//
// Input channel: one file byte per transfer on byte_valid/byte_ready, with
// first high on byte 0 of a file to restart parsing at the header.
// Output channel: result_valid/result_ready carry one result per transfer:
// a header result (kind header accepted, width in column, height in row),
// an error result (bad type or bad depth, last high), or one RGBA pixel with
// its column and destination row. Header bytes other than the last and all
// but the final byte of each pixel produce no result.
// Path: a byte is held in the input register, and its result is loaded into
// the result register when the byte leaves the input register; this waits
// while the result register is full and the receiver does not take it.
// Throughput: one byte per cycle while the result register has space, set
// by the single parse step each byte takes between the two registers.
// Reset: parsing restarts in the header phase, both registers are empty.
// Receiver stall: the result register holds its transfer, the input register
// takes one more byte, then byte_ready drops until result_ready returns.
`include "assert_macros.svh"
module tga_truecolor_to_rgba_stream_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_ready,
  input  logic [7:0]                  file_byte,
  input  logic                        first,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [1:0]                  kind,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic [7:0]                  alpha,
  output logic [tga_pkg::COORD_W-1:0] column,
  output logic [tga_pkg::COORD_W-1:0] row,
  output logic                        last
);
  import tga_pkg::*;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_first;
  logic       space;
  logic       advance;
  logic       res_valid;
  res_t       res;
  res_t       out_data;

  assign advance    = in_valid && space;
  assign byte_ready = !in_valid || space;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_byte  <= file_byte;
      in_first <= first;
    end
  end

  tga_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .file_byte (in_byte),
    .first     (in_first),
    .res_valid (res_valid),
    .res       (res)
  );

  tga_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && res_valid),
    .push_data (res),
    .pop_ready (result_ready),
    .full      (result_valid),
    .space     (space),
    .data      (out_data)
  );

  assign kind   = out_data.kind;
  assign red    = out_data.red;
  assign green  = out_data.green;
  assign blue   = out_data.blue;
  assign alpha  = out_data.alpha;
  assign column = out_data.column;
  assign row    = out_data.row;
  assign last   = out_data.last;

  `ASSERT_IMPLIES(a_err_last, clk, rst, result_valid && (kind == KIND_BAD_TYPE || kind == KIND_BAD_DEPTH), last)
  `ASSERT_IMPLIES(a_nonpix_zero, clk, rst, result_valid && kind != KIND_PIXEL, red == 8'd0 && green == 8'd0 && blue == 8'd0 && alpha == 8'd0)
  `ASSERT_IMPLIES(a_stall_full, clk, rst, !byte_ready, in_valid && result_valid)
  `ASSERT_NEXT(a_in_load, clk, rst, byte_valid && byte_ready, in_valid)

endmodule

/* design/tga_parse.sv */
// Header parser and pixel assembler: decoder state and per-byte result logic.
module tga_parse (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    file_byte,
  input  logic          first,
  output logic          res_valid,
  output tga_pkg::res_t res
);
  import tga_pkg::*;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_PIXELS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  localparam logic [4:0] HDR_TYPE    = 5'd2;
  localparam logic [4:0] HDR_WIDTH_L = 5'd12;
  localparam logic [4:0] HDR_WIDTH_H = 5'd13;
  localparam logic [4:0] HDR_HEIGHT_L = 5'd14;
  localparam logic [4:0] HDR_HEIGHT_H = 5'd15;
  localparam logic [4:0] HDR_DEPTH   = 5'd16;
  localparam logic [4:0] HDR_DESC    = 5'd17;
  localparam logic [7:0] TYPE_TRUECOLOR = 8'd2;
  localparam logic [4:0] BPP_RGB     = 5'd3;
  localparam logic [4:0] BPP_RGBA    = 5'd4;
  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  phase_t             phase, phase_next;
  logic [4:0]         header_count, header_count_next;
  logic [7:0]         image_type, image_type_next;
  logic [DIM_W-1:0]   image_width, image_width_next;
  logic [DIM_W-1:0]   image_height, image_height_next;
  logic [4:0]         bytes_per_pixel, bytes_per_pixel_next;
  logic               top_origin, top_origin_next;
  logic [4:0]         byte_in_pixel, byte_in_pixel_next;
  logic [COORD_W-1:0] cur_column, cur_column_next;
  logic [COORD_W-1:0] cur_line, cur_line_next;
  logic [7:0]         held [3];
  logic [7:0]         held_next [3];

  phase_t             ph;
  logic [4:0]         hc;
  logic [DIM_W-1:0]   width_lim, height_lim;
  logic               col_end, line_end;

  always_comb begin
    ph = first ? PH_HEADER : phase;
    hc = first ? 5'd0 : header_count;
    width_lim  = limit_dim(image_width);
    height_lim = limit_dim(image_height);
    col_end  = ({1'b0, cur_column} + 16'd1) == image_width;
    line_end = ({1'b0, cur_line} + 16'd1) == image_height;

    phase_next           = ph;
    header_count_next    = hc;
    image_type_next      = image_type;
    image_width_next     = image_width;
    image_height_next    = image_height;
    bytes_per_pixel_next = bytes_per_pixel;
    top_origin_next      = top_origin;
    byte_in_pixel_next   = byte_in_pixel;
    cur_column_next      = cur_column;
    cur_line_next        = cur_line;
    held_next            = held;
    res_valid            = 1'b0;
    res                  = '0;

    unique case (ph)
      PH_HEADER: begin
        if (hc == HDR_TYPE)     image_type_next = file_byte;
        if (hc == HDR_WIDTH_L)  image_width_next = {image_width[15:8], file_byte};
        if (hc == HDR_WIDTH_H)  image_width_next = {file_byte, image_width[7:0]};
        if (hc == HDR_HEIGHT_L) image_height_next = {image_height[15:8], file_byte};
        if (hc == HDR_HEIGHT_H) image_height_next = {file_byte, image_height[7:0]};
        if (hc == HDR_DEPTH) begin
          bytes_per_pixel_next = file_byte[7] ? 5'd0 : 5'(file_byte >> 3);
        end
        if (hc < HDR_DESC) begin
          header_count_next = hc + 5'd1;
        end else begin
          top_origin_next = file_byte[5];
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (image_type != TYPE_TRUECOLOR) begin
            phase_next = PH_DONE;
            res.kind   = KIND_BAD_TYPE;
          end else if (bytes_per_pixel < BPP_RGB) begin
            phase_next = PH_DONE;
            res.kind   = KIND_BAD_DEPTH;
          end else begin
            image_width_next   = width_lim;
            image_height_next  = height_lim;
            byte_in_pixel_next = '0;
            cur_column_next    = '0;
            cur_line_next      = '0;
            res.kind   = KIND_HEADER;
            res.column = width_lim[COORD_W-1:0];
            res.row    = height_lim[COORD_W-1:0];
            if (width_lim == '0 || height_lim == '0) begin
              phase_next = PH_DONE;
            end else begin
              phase_next = PH_PIXELS;
              res.last   = 1'b0;
            end
          end
        end
      end
      PH_PIXELS: begin
        if (byte_in_pixel < BPP_RGB) held_next[byte_in_pixel[1:0]] = file_byte;
        if (({1'b0, byte_in_pixel} + 6'd1) < {1'b0, bytes_per_pixel}) begin
          byte_in_pixel_next = byte_in_pixel + 5'd1;
        end else begin
          byte_in_pixel_next = '0;
          res_valid  = 1'b1;
          res.kind   = KIND_PIXEL;
          res.red    = (byte_in_pixel == 5'd2) ? file_byte : held[2];
          res.green  = held[1];
          res.blue   = held[0];
          res.alpha  = (bytes_per_pixel == BPP_RGBA) ? file_byte : ALPHA_OPAQUE;
          res.column = cur_column;
          res.row    = top_origin ? cur_line
                                  : (image_height[COORD_W-1:0] - 15'd1 - cur_line);
          res.last   = col_end && line_end;
          if (col_end && line_end) begin
            phase_next = PH_DONE;
          end else if (col_end) begin
            cur_column_next = '0;
            cur_line_next   = cur_line + 15'd1;
          end else begin
            cur_column_next = cur_column + 15'd1;
          end
        end
      end
      PH_DONE: begin
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      header_count    <= '0;
      image_type      <= '0;
      image_width     <= '0;
      image_height    <= '0;
      bytes_per_pixel <= '0;
      top_origin      <= 1'b0;
      byte_in_pixel   <= '0;
      cur_column      <= '0;
      cur_line        <= '0;
      held            <= '{default: 8'd0};
    end else if (step) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      image_type      <= image_type_next;
      image_width     <= image_width_next;
      image_height    <= image_height_next;
      bytes_per_pixel <= bytes_per_pixel_next;
      top_origin      <= top_origin_next;
      byte_in_pixel   <= byte_in_pixel_next;
      cur_column      <= cur_column_next;
      cur_line        <= cur_line_next;
      held            <= held_next;
    end
  end

endmodule

/* design/tga_out_buf.sv */
// Result register between the decoder logic and the output channel.
module tga_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tga_pkg::res_t push_data,
  input  logic          pop_ready,
  output logic          full,
  output logic          space,
  output tga_pkg::res_t data
);
  import tga_pkg::*;

  assign space = !full || pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (pop_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data <= push_data;
    end
  end

endmodule
